// File: sv/assert_macros.svh
// assertion macros shared by the sorted store rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define SARS_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("sorted store assertion failed");

`define SARS_ASSERT_NEVER(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("sorted store forbidden condition seen");

`else

`define SARS_ASSERT(lbl, clk, rst_n, prop)

`define SARS_ASSERT_NEVER(lbl, clk, rst_n, expr)

`endif

`endif

// File: sv/sars_pkg.sv
// types and constants of the sorted replace store
`timescale 1ns / 1ps
`default_nettype none

package sars_pkg;

    localparam int ENTRIES = 16;
    localparam int WORD_W  = 32;
    localparam int SLOT_W  = 8;
    localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

    typedef logic [WORD_W-1:0] word_t;
    typedef logic [SLOT_W-1:0] slot_t;
    typedef logic [IDX_W-1:0]  idx_t;

    localparam word_t WORD_ALL_ONES = '1;

    localparam logic REQ_READ    = 1'b0;
    localparam logic REQ_REPLACE = 1'b1;

    typedef struct packed {
        logic  wr;
        logic  up;
        logic  at_slot;
        logic  above_slot;
        logic  below_slot;
        word_t word;
    } cell_ctrl_t;

endpackage

`default_nettype wire

// File: sv/sars_req_if.sv
// request and response channel interfaces of the sorted replace store
`timescale 1ns / 1ps
`default_nettype none

interface sars_req_if
    import sars_pkg::*;
();
    logic  valid;
    logic  ready;
    logic  req_type;
    slot_t slot_index;
    word_t new_word;

    modport source (output valid, output req_type, output slot_index, output new_word,
                    input ready);
    modport sink   (input valid, input req_type, input slot_index, input new_word,
                    output ready);
endinterface

interface sars_rsp_if
    import sars_pkg::*;
();
    logic  valid;
    logic  ready;
    word_t read_word;
    logic  range_error;

    modport source (output valid, output read_word, output range_error, input ready);
    modport sink   (input valid, input read_word, input range_error, output ready);
endinterface

`default_nettype wire

// File: sv/sars_cell.sv
// one slot of the sorted row: holds a word and shifts with its neighbors
`timescale 1ns / 1ps
`default_nettype none

module sars_cell
    import sars_pkg::*;
(
    input  wire        clk,
    input  wire        rst_n,
    input  cell_ctrl_t ctrl,
    input  word_t      upper_word,
    input  logic       upper_lt,
    input  word_t      lower_word,
    input  logic       lower_gt,
    output word_t      word,
    output logic       lt,
    output logic       gt
);

    word_t word_reg;
    word_t word_next;

    assign word = word_reg;
    assign lt   = word_reg < ctrl.word;
    assign gt   = word_reg > ctrl.word;

    always_comb
    begin
        word_next = word_reg;
        if (ctrl.wr)
        begin
            if (ctrl.up)
            begin
                if (ctrl.at_slot || ctrl.above_slot)
                begin
                    if (upper_lt)
                    begin
                        word_next = upper_word;
                    end
                    else if (ctrl.at_slot || lt)
                    begin
                        word_next = ctrl.word;
                    end
                end
            end
            else
            begin
                if (ctrl.at_slot || ctrl.below_slot)
                begin
                    if (lower_gt)
                    begin
                        word_next = lower_word;
                    end
                    else if (ctrl.at_slot || gt)
                    begin
                        word_next = ctrl.word;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            word_reg <= WORD_ALL_ONES;
        end
        else
        begin
            word_reg <= word_next;
        end
    end

endmodule

`default_nettype wire

// File: sv/sorted_array_replace_store.sv
// Sorted store of ENTRIES unsigned 32-bit words kept in ascending order, reset to all ones
// (no clearing pass, the store is usable right after reset). A replace removes the word at
// the slot and inserts the new word in order; a read returns the word at the slot; a slot at
// or beyond ENTRIES flags range_error, returns zero and leaves the store alone. One request
// is taken per cycle: a row of cells, each comparing the new word with its own word and
// trading words with its neighbors, settles the whole replace combinationally, and the result
// appears in the next cycle in an output register that keeps taking requests while the
// response side is ready.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module sorted_array_replace_store
    import sars_pkg::*;
(
    input  wire         clk,
    input  wire         rst_n,
    sars_req_if.sink    req,
    sars_rsp_if.source  rsp
);

    word_t                         cell_word [ENTRIES];
    logic  [ENTRIES-1:0]           cell_lt;
    logic  [ENTRIES-1:0]           cell_gt;
    logic  [ENTRIES-1:0][WORD_W-1:0] store_flat;

    logic  req_fire;
    logic  in_range;
    idx_t  idx_sel;
    word_t slot_word;

    logic  rsp_valid_reg;
    logic  rsp_valid_next;
    word_t read_word_reg;
    logic  range_error_reg;

    assign req_fire  = req.valid && req.ready;
    assign in_range  = {1'b0, req.slot_index} < (SLOT_W + 1)'(ENTRIES);
    assign idx_sel   = req.slot_index[IDX_W-1:0];
    assign slot_word = cell_word[idx_sel];
    assign req.ready = !rsp_valid_reg || rsp.ready;

    genvar i;
    generate
        for (i = 0; i < ENTRIES; i++)
        begin : g_cell
            cell_ctrl_t ctrl;
            word_t      upper_word;
            logic       upper_lt;
            word_t      lower_word;
            logic       lower_gt;

            assign ctrl.wr         = req_fire && in_range && (req.req_type == REQ_REPLACE);
            assign ctrl.up         = req.new_word >= slot_word;
            assign ctrl.at_slot    = IDX_W'(i) == idx_sel;
            assign ctrl.above_slot = IDX_W'(i) > idx_sel;
            assign ctrl.below_slot = IDX_W'(i) < idx_sel;
            assign ctrl.word       = req.new_word;

            if (i == ENTRIES - 1)
            begin : g_top_end
                assign upper_word = WORD_ALL_ONES;
                assign upper_lt   = 1'b0;
            end
            else
            begin : g_top_link
                assign upper_word = cell_word[i+1];
                assign upper_lt   = cell_lt[i+1];
            end

            if (i == 0)
            begin : g_bot_end
                assign lower_word = '0;
                assign lower_gt   = 1'b0;
            end
            else
            begin : g_bot_link
                assign lower_word = cell_word[i-1];
                assign lower_gt   = cell_gt[i-1];
            end

            sars_cell u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .ctrl       (ctrl),
                .upper_word (upper_word),
                .upper_lt   (upper_lt),
                .lower_word (lower_word),
                .lower_gt   (lower_gt),
                .word       (cell_word[i]),
                .lt         (cell_lt[i]),
                .gt         (cell_gt[i])
            );

            assign store_flat[i] = cell_word[i];
        end
    endgenerate

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (req_fire)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_fire)
        begin
            range_error_reg <= !in_range;
            read_word_reg   <= (in_range && (req.req_type == REQ_READ)) ? slot_word : '0;
        end
    end

    assign rsp.valid       = rsp_valid_reg;
    assign rsp.read_word   = read_word_reg;
    assign rsp.range_error = range_error_reg;

    generate
        for (i = 0; i + 1 < ENTRIES; i++)
        begin : g_order_chk
            `SARS_ASSERT(a_row_sorted, clk, rst_n, cell_word[i] <= cell_word[i+1])
        end
    endgenerate

    `SARS_ASSERT(a_bad_slot_keeps_store, clk, rst_n, req_fire && !in_range |=> $stable(store_flat))
    `SARS_ASSERT(a_read_keeps_store, clk, rst_n, req_fire && (req.req_type == REQ_READ) |=> $stable(store_flat))
    `SARS_ASSERT(a_fire_gives_result, clk, rst_n, req_fire |=> rsp_valid_reg)
    `SARS_ASSERT_NEVER(a_error_word_zero, clk, rst_n, rsp_valid_reg && range_error_reg && (read_word_reg != '0))

endmodule

`default_nettype wire

// File: sim/sars_store_checker.sv
// checker for the sorted replace store: predicts each response and compares it
`timescale 1ns / 1ps

module sars_store_checker
    import sars_pkg::*;
(
    input  wire  clk,
    input  wire  rst_n,
    sars_req_if  req,
    sars_rsp_if  rsp,
    output int   fail_count,
    output int   pending
);

    typedef struct {
        word_t read_word;
        logic  range_error;
    } rsp_item_t;

    word_t     shadow_words [ENTRIES];
    rsp_item_t expected_rsps [$];

    initial begin
        fail_count = 0;
        pending    = 0;
    end

    task automatic report_mismatch(input string what);
        $display("ERROR %0t: %s", $time, what);
        fail_count++;
    endtask

    function automatic void insert_sorted(input int unsigned slot, input word_t w);
        int unsigned pos;
        word_t       tmp;
        pos = slot;
        shadow_words[slot] = w;
        while (pos + 1 < ENTRIES && shadow_words[pos] > shadow_words[pos+1]) begin
            tmp                  = shadow_words[pos];
            shadow_words[pos]    = shadow_words[pos+1];
            shadow_words[pos+1]  = tmp;
            pos++;
        end
        if (pos == slot) begin
            while (pos > 0 && shadow_words[pos] < shadow_words[pos-1]) begin
                tmp                  = shadow_words[pos];
                shadow_words[pos]    = shadow_words[pos-1];
                shadow_words[pos-1]  = tmp;
                pos--;
            end
        end
    endfunction

    always @(posedge clk or negedge rst_n) begin
        rsp_item_t want;
        if (!rst_n) begin
            for (int i = 0; i < ENTRIES; i++)
                shadow_words[i] = WORD_ALL_ONES;
            expected_rsps.delete();
            pending <= 0;
        end
        else begin
            if (rsp.valid && rsp.ready) begin
                if (expected_rsps.size() == 0) begin
                    report_mismatch("response transaction with no request pending");
                end
                else begin
                    want = expected_rsps.pop_front();
                    if (rsp.read_word !== want.read_word)
                        report_mismatch($sformatf("read_word got %h expected %h",
                                                  rsp.read_word, want.read_word));
                    if (rsp.range_error !== want.range_error)
                        report_mismatch($sformatf("range_error got %b expected %b",
                                                  rsp.range_error, want.range_error));
                end
            end
            if (req.valid && req.ready) begin
                want.read_word   = '0;
                want.range_error = 1'b0;
                if (req.slot_index >= ENTRIES)
                    want.range_error = 1'b1;
                else if (req.req_type == REQ_REPLACE)
                    insert_sorted(req.slot_index, req.new_word);
                else
                    want.read_word = shadow_words[req.slot_index];
                expected_rsps.push_back(want);
            end
            pending <= expected_rsps.size();
        end
    end

endmodule

// File: sim/tb_sorted_array_replace_store.sv
// top of the sorted replace store testbench: clock, reset, stimulus and verdict
`timescale 1ns / 1ps

module tb_sorted_array_replace_store;
    import sars_pkg::*;

    logic clk = 1'b0;
    logic rst_n;
    logic no_idle;
    int   fail_count;
    int   pending;

    sars_req_if req_ch ();
    sars_rsp_if rsp_ch ();

    sorted_array_replace_store uut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    sars_store_checker chk (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (req_ch),
        .rsp        (rsp_ch),
        .fail_count (fail_count),
        .pending    (pending)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic int draw_gap();
        return no_idle ? 0 : $urandom_range(0, 19);
    endfunction

    function automatic word_t draw_word();
        case ($urandom_range(0, 3))
            0:       return word_t'($urandom_range(0, 7));
            1:       return WORD_ALL_ONES - word_t'($urandom_range(0, 7));
            default: return word_t'($urandom);
        endcase
    endfunction

    function automatic slot_t draw_slot();
        if ($urandom_range(0, 9) == 0)
            return slot_t'($urandom_range(0, 255));
        return slot_t'($urandom_range(0, ENTRIES - 1));
    endfunction

    // caller is at a falling edge; returns at the falling edge after acceptance
    task automatic send_request(input logic kind, input slot_t slot, input word_t w);
        int gap;
        gap = draw_gap();
        if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        req_ch.valid      <= 1'b1;
        req_ch.req_type   <= kind;
        req_ch.slot_index <= slot;
        req_ch.new_word   <= w;
        do @(posedge clk); while (!req_ch.ready);
        @(negedge clk);
    endtask

    initial begin
        rst_n = 1'b0;
        no_idle = 1'b0;
        req_ch.valid = 1'b0;
        req_ch.req_type = REQ_READ;
        req_ch.slot_index = '0;
        req_ch.new_word = '0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        send_request(REQ_READ, slot_t'(0), '0);
        send_request(REQ_READ, slot_t'(ENTRIES - 1), WORD_ALL_ONES);
        send_request(REQ_READ, slot_t'(ENTRIES), '0);
        send_request(REQ_READ, '1, WORD_ALL_ONES);
        send_request(REQ_REPLACE, '1, '0);
        send_request(REQ_REPLACE, slot_t'(ENTRIES), 32'd3);
        send_request(REQ_REPLACE, slot_t'(0), '0);
        send_request(REQ_REPLACE, slot_t'(ENTRIES - 1), 32'd5);
        send_request(REQ_REPLACE, slot_t'(0), WORD_ALL_ONES);
        send_request(REQ_REPLACE, slot_t'(3), 32'd5);
        send_request(REQ_REPLACE, slot_t'(7), 32'd5);
        send_request(REQ_REPLACE, slot_t'(2), 32'd5);
        send_request(REQ_REPLACE, slot_t'(0), 32'h8000_0000);
        send_request(REQ_REPLACE, slot_t'(ENTRIES - 1), '0);
        send_request(REQ_REPLACE, slot_t'(8), 32'hAAAA_AAAA);
        send_request(REQ_REPLACE, slot_t'(9), 32'h5555_5555);
        for (int s = 0; s < ENTRIES; s += 5)
            send_request(REQ_READ, slot_t'(s), 32'hDEAD_BEEF);
        send_request(REQ_READ, slot_t'(ENTRIES - 1), '0);

        for (int n = 0; n < 1150; n++) begin
            if (n % 100 == 0)
                no_idle = ($urandom_range(0, 3) == 0);
            if (n == 600) begin
                req_ch.valid <= 1'b0;
                while (pending != 0) @(negedge clk);
            end
            send_request(logic'($urandom_range(0, 1)), draw_slot(), draw_word());
        end
        req_ch.valid <= 1'b0;

        while (pending != 0) @(posedge clk);
        repeat (5) @(posedge clk);
        if (fail_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    initial begin
        int stall;
        rsp_ch.ready = 1'b0;
        @(posedge rst_n);
        @(negedge clk);
        forever begin
            stall = draw_gap();
            if (stall > 0) begin
                rsp_ch.ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            rsp_ch.ready <= 1'b1;
            do @(posedge clk); while (!rsp_ch.valid);
            @(negedge clk);
        end
    end

    initial begin
        #5_000_000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule

// File: sim.f
+incdir+sv
sv/sars_pkg.sv
sv/sars_req_if.sv
sv/sars_cell.sv
sv/sorted_array_replace_store.sv
sim/sars_store_checker.sv
sim/tb_sorted_array_replace_store.sv
